### src/tsm_pkg.sv
// Package for the takeover safety monitor: word and config types,
// register indexes, mode codes, fault bits and decel constants. No dependencies.
package tsm_pkg;

  // APB register map
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [1:0] REG_FRAME_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_OVERRUN_LIMIT = 2'd1;
  localparam logic [1:0] REG_LOAD_LIMIT    = 2'd2;
  localparam logic [1:0] REG_ERROR_MASK    = 2'd3;

  // Mode codes as seen on the result word
  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_DEGRADED = 3'd1;
  localparam logic [2:0] MODE_CSTOP    = 3'd2;
  localparam logic [2:0] MODE_TAKEOVER = 3'd3;
  localparam logic [2:0] MODE_SAFE     = 3'd4;

  // Fault bit positions
  localparam int unsigned FLT_TIMEOUT = 0;
  localparam int unsigned FLT_STALL   = 1;
  localparam int unsigned FLT_OVERRUN = 2;
  localparam int unsigned FLT_CPU     = 3;
  localparam int unsigned FLT_PRIMARY = 4;

  localparam logic [1:0] STALL_MAX = 2'd3;
  localparam logic signed [15:0] STOP_SPEED = 16'sd100;

  // Decel commands in mm/s^2
  localparam logic signed [11:0] DECEL_NONE     = 12'sd0;
  localparam logic signed [11:0] DECEL_CSTOP    = -12'sd1200;
  localparam logic signed [11:0] DECEL_TAKEOVER = -12'sd2000;
  localparam logic signed [11:0] DECEL_SAFE     = -12'sd500;

  localparam logic ACT_FRAME = 1'b0;

  typedef struct packed {
    logic [31:0] frame_timeout;
    logic [31:0] overrun_limit;
    logic [15:0] load_limit;
    logic [15:0] error_mask;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic [31:0]        now_time;
    logic [31:0]        frame_seq;
    logic [31:0]        overrun_count;
    logic [15:0]        cpu_load;
    logic [15:0]        error_bits;
    logic signed [15:0] speed;
  } item_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [4:0]         faults;
    logic               authority;
    logic signed [11:0] decel;
  } result_t;

endpackage

### src/tsm_cfg_regs.sv
// APB configuration registers of the takeover safety monitor.
// Depends on tsm_pkg.
module tsm_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tsm_pkg::AddrW-1:0] paddr,
  input  logic [tsm_pkg::DataW-1:0] pwdata,
  output logic [tsm_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output tsm_pkg::cfg_t             cfg_o
);
  import tsm_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  // register write, reset to documented defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_timeout <= 32'd100;
      cfg_q.overrun_limit <= 32'd0;
      cfg_q.load_limit    <= 16'd1000;
      cfg_q.error_mask    <= 16'd3;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRAME_TIMEOUT: cfg_q.frame_timeout <= pwdata;
        REG_OVERRUN_LIMIT: cfg_q.overrun_limit <= pwdata;
        REG_LOAD_LIMIT:    cfg_q.load_limit    <= pwdata[15:0];
        REG_ERROR_MASK:    cfg_q.error_mask    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_FRAME_TIMEOUT: prdata = cfg_q.frame_timeout;
      REG_OVERRUN_LIMIT: prdata = cfg_q.overrun_limit;
      REG_LOAD_LIMIT:    prdata = {16'd0, cfg_q.load_limit};
      REG_ERROR_MASK:    prdata = {16'd0, cfg_q.error_mask};
      default:           prdata = '0;
    endcase
  end

endmodule

### src/tsm_core.sv
// Monitor state and next-state logic: sequence stall check, fault latch,
// frame timeout and the mode machine. Depends on tsm_pkg.
module tsm_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  tsm_pkg::item_t   item_i,
  input  tsm_pkg::cfg_t    cfg_i,
  output tsm_pkg::result_t res_o
);
  import tsm_pkg::*;

  typedef enum logic [2:0] {
    ST_NORMAL   = MODE_NORMAL,
    ST_DEGRADED = MODE_DEGRADED,
    ST_CSTOP    = MODE_CSTOP,
    ST_TAKEOVER = MODE_TAKEOVER,
    ST_SAFE     = MODE_SAFE
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [31:0] prev_seq_q, prev_seq_d;
  logic [31:0] last_time_q, last_time_d;
  logic [1:0]  stall_q, stall_d, stall_inc;
  logic [4:0]  fault_q, fault_d;
  logic        is_frame, seq_stalled, lost, slow;
  logic [31:0] elapsed;

  assign is_frame    = (item_i.action == ACT_FRAME);
  assign seq_stalled = (item_i.frame_seq <= prev_seq_q) && (prev_seq_q != 32'd0);
  assign stall_inc   = (stall_q < STALL_MAX) ? stall_q + 2'd1 : STALL_MAX;
  assign elapsed     = item_i.now_time - last_time_q;
  assign lost        = elapsed > cfg_i.frame_timeout;
  assign slow        = item_i.speed < STOP_SPEED;

  // frame bookkeeping and fault latch
  always_comb begin
    prev_seq_d  = prev_seq_q;
    last_time_d = last_time_q;
    stall_d     = stall_q;
    fault_d     = fault_q;
    if (is_frame) begin
      last_time_d = item_i.now_time;
      prev_seq_d  = item_i.frame_seq;
      if (seq_stalled) begin
        stall_d = stall_inc;
        if (stall_inc == STALL_MAX) fault_d[FLT_STALL] = 1'b1;
      end else begin
        stall_d = 2'd0;
      end
      if (item_i.overrun_count > cfg_i.overrun_limit) fault_d[FLT_OVERRUN] = 1'b1;
      if (item_i.cpu_load > cfg_i.load_limit) fault_d[FLT_CPU] = 1'b1;
      if ((item_i.error_bits & cfg_i.error_mask) != 16'd0) fault_d[FLT_PRIMARY] = 1'b1;
    end else if (lost) begin
      fault_d[FLT_TIMEOUT] = 1'b1;
    end
  end

  // mode machine, moves on ticks only
  always_comb begin
    mode_d = mode_q;
    if (!is_frame) begin
      case (mode_q)
        ST_NORMAL: begin
          if (fault_d[FLT_TIMEOUT] || fault_d[FLT_STALL]) mode_d = ST_TAKEOVER;
          else if (fault_d != 5'd0) mode_d = ST_DEGRADED;
        end
        ST_DEGRADED: begin
          if (fault_d[FLT_TIMEOUT] || fault_d[FLT_STALL]) mode_d = ST_TAKEOVER;
          else if (fault_d[FLT_OVERRUN] || fault_d[FLT_PRIMARY]) mode_d = ST_CSTOP;
        end
        ST_CSTOP: begin
          if (slow) mode_d = ST_SAFE;
          else if (lost) mode_d = ST_TAKEOVER;
        end
        ST_TAKEOVER: begin
          if (slow) mode_d = ST_SAFE;
        end
        default: mode_d = mode_q;
      endcase
    end
  end

  // result word for this item
  always_comb begin
    res_o.mode      = mode_d;
    res_o.faults    = fault_d;
    res_o.authority = (mode_d == ST_TAKEOVER) || (mode_d == ST_SAFE);
    case (mode_d)
      ST_CSTOP:    res_o.decel = DECEL_CSTOP;
      ST_TAKEOVER: res_o.decel = DECEL_TAKEOVER;
      ST_SAFE:     res_o.decel = DECEL_SAFE;
      default:     res_o.decel = DECEL_NONE;
    endcase
  end

  // state and registered bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ST_NORMAL;
      prev_seq_q  <= '0;
      last_time_q <= '0;
      stall_q     <= '0;
      fault_q     <= '0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      prev_seq_q  <= prev_seq_d;
      last_time_q <= last_time_d;
      stall_q     <= stall_d;
      fault_q     <= fault_d;
    end
  end

endmodule

### src/takeover_safety_monitor_top.sv
// Top level of the takeover safety monitor: input word register, core,
// result register and APB registers. Depends on tsm_pkg, tsm_cfg_regs, tsm_core.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   input    | in_valid_i / in_ready_o   | action, now_time, frame_seq, overrun_count,
//            |                           | cpu_load, error_bits, speed
//   result   | out_valid_o / out_ready_i | mode, faults, authority, decel
//   config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One word per cycle while the result channel is not stalled. A word is held in
// the input register; its result is computed from that register and the monitor
// state and lands in the result register, whose valid flag drives out_valid_o.
// Reset clears the mode, fault latch, sequence and timing state and the config
// registers to their defaults. A stalled result holds the result register; the
// input register keeps taking words while it or the result register can move.
module takeover_safety_monitor_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      action_i,
  input  logic [31:0]               now_time_i,
  input  logic [31:0]               frame_seq_i,
  input  logic [31:0]               overrun_count_i,
  input  logic [15:0]               cpu_load_i,
  input  logic [15:0]               error_bits_i,
  input  logic signed [15:0]        speed_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                mode_o,
  output logic [4:0]                faults_o,
  output logic                      authority_o,
  output logic signed [11:0]        decel_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tsm_pkg::AddrW-1:0] paddr,
  input  logic [tsm_pkg::DataW-1:0] pwdata,
  output logic [tsm_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import tsm_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  result_t res_d, res_q;
  logic    item_vld_q, item_vld_d;
  logic    out_vld_q, out_vld_d;
  logic    out_free, step, in_take;

  tsm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake control
  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = item_vld_q && out_free;
  assign in_ready_o = !item_vld_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;
  assign item_vld_d = in_take || (item_vld_q && !out_free);
  assign out_vld_d  = step || (out_vld_q && !out_ready_i);

  tsm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action        <= action_i;
      item_q.now_time      <= now_time_i;
      item_q.frame_seq     <= frame_seq_i;
      item_q.overrun_count <= overrun_count_i;
      item_q.cpu_load      <= cpu_load_i;
      item_q.error_bits    <= error_bits_i;
      item_q.speed         <= speed_i;
    end
    if (step) res_q <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign mode_o      = res_q.mode;
  assign faults_o    = res_q.faults;
  assign authority_o = res_q.authority;
  assign decel_o     = res_q.decel;

  // safe stop is latched until reset
  a_safe_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.mode == MODE_SAFE) |=> (res_q.mode == MODE_SAFE))
    else $error("safe stop left without reset");

  // faults never clear once shown
  a_faults_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |=> ((res_q.faults & $past(res_q.faults)) == $past(res_q.faults)))
    else $error("latched fault cleared");

  // a stalled result register must not be overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |-> !step)
    else $error("result overwritten while stalled");

  // no authority without a commanded decel
  a_auth_decel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.authority) |-> (res_q.decel != DECEL_NONE))
    else $error("authority without decel command");

endmodule

### test/takeover_safety_monitor_top_test.sv
// Testbench for takeover_safety_monitor_top: drives frames and ticks, predicts every
// status word in a local model of the monitor and compares it field by field.
// Depends on tsm_pkg and takeover_safety_monitor_top.
module takeover_safety_monitor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsm_pkg::*;

  localparam logic ACT_TICK = ~ACT_FRAME;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic clk_i;
  logic rst_ni = 1'b0;

  // input channel
  logic in_valid = 1'b0;
  logic in_ready_o;
  item_t in_word = '0;

  // result channel
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] mode_o;
  logic [4:0] faults_o;
  logic authority_o;
  logic signed [11:0] decel_o;

  // config port
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  // predicted monitor state and config
  cfg_t shadow_cfg;
  logic [2:0] m_mode;
  logic [31:0] m_prev_seq;
  logic [31:0] m_last_time;
  logic [1:0] m_stall;
  logic [4:0] m_faults;

  result_t expected_status[$];
  int unsigned mismatch_count = 0;

  // stimulus-side view of the sequence numbers sent so far
  logic [31:0] gen_prev_seq = '0;
  int unsigned gen_stall_run = 0;

  bit tx_gaps_on = 1'b0;
  bit rx_stalls_on = 1'b0;
  int unsigned ready_hold = 0;

  takeover_safety_monitor_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .action_i       (in_word.action),
    .now_time_i     (in_word.now_time),
    .frame_seq_i    (in_word.frame_seq),
    .overrun_count_i(in_word.overrun_count),
    .cpu_load_i     (in_word.cpu_load),
    .error_bits_i   (in_word.error_bits),
    .speed_i        (in_word.speed),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mode_o         (mode_o),
    .faults_o       (faults_o),
    .authority_o    (authority_o),
    .decel_o        (decel_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Applies one word to the predicted state and returns the status it should produce
  function automatic result_t advance_monitor(input item_t w);
    logic [31:0] elapsed;
    logic lost;
    logic slow;
    result_t r;
    if (w.action == ACT_FRAME) begin
      m_last_time = w.now_time;
      if (w.frame_seq <= m_prev_seq && m_prev_seq != 0) begin
        if (m_stall < STALL_MAX) m_stall++;
        if (m_stall == STALL_MAX) m_faults[FLT_STALL] = 1'b1;
      end else begin
        m_stall = '0;
      end
      m_prev_seq = w.frame_seq;
      if (w.overrun_count > shadow_cfg.overrun_limit) m_faults[FLT_OVERRUN] = 1'b1;
      if (w.cpu_load > shadow_cfg.load_limit) m_faults[FLT_CPU] = 1'b1;
      if ((w.error_bits & shadow_cfg.error_mask) != 0) m_faults[FLT_PRIMARY] = 1'b1;
    end else begin
      elapsed = w.now_time - m_last_time;
      lost = elapsed > shadow_cfg.frame_timeout;
      slow = $signed(w.speed) < $signed(STOP_SPEED);
      if (lost) m_faults[FLT_TIMEOUT] = 1'b1;
      case (m_mode)
        MODE_NORMAL: begin
          if (m_faults[FLT_TIMEOUT] || m_faults[FLT_STALL]) m_mode = MODE_TAKEOVER;
          else if (m_faults != 0) m_mode = MODE_DEGRADED;
        end
        MODE_DEGRADED: begin
          if (m_faults[FLT_TIMEOUT] || m_faults[FLT_STALL]) m_mode = MODE_TAKEOVER;
          else if (m_faults[FLT_OVERRUN] || m_faults[FLT_PRIMARY]) m_mode = MODE_CSTOP;
        end
        MODE_CSTOP: begin
          if (lost) m_mode = MODE_TAKEOVER;
          if (slow) m_mode = MODE_SAFE;
        end
        MODE_TAKEOVER: begin
          if (slow) m_mode = MODE_SAFE;
        end
        default: ;
      endcase
    end
    r.mode = m_mode;
    r.faults = m_faults;
    r.authority = (m_mode == MODE_TAKEOVER) || (m_mode == MODE_SAFE);
    case (m_mode)
      MODE_CSTOP:    r.decel = DECEL_CSTOP;
      MODE_TAKEOVER: r.decel = DECEL_TAKEOVER;
      MODE_SAFE:     r.decel = DECEL_SAFE;
      default:       r.decel = DECEL_NONE;
    endcase
    return r;
  endfunction

  // Predict on every accepted word, check every accepted status word
  always @(posedge clk_i) begin : track_status
    result_t want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) expected_status.push_back(advance_monitor(in_word));
      if (out_valid_o && out_ready_i) begin
        if (expected_status.size() == 0) begin
          flag_mismatch("status word with nothing outstanding");
        end else begin
          want = expected_status.pop_front();
          if (mode_o !== want.mode)
            flag_mismatch($sformatf("mode %0d, expected %0d", mode_o, want.mode));
          if (faults_o !== want.faults)
            flag_mismatch($sformatf("faults %b, expected %b", faults_o, want.faults));
          if (authority_o !== want.authority)
            flag_mismatch($sformatf("authority %b, expected %b", authority_o, want.authority));
          if (decel_o !== want.decel)
            flag_mismatch($sformatf("decel %0d, expected %0d", decel_o, want.decel));
        end
      end
    end
  end

  // Result side: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !rx_stalls_on || ($urandom_range(99) >= 37);
    end
  end

  // One APB transfer; a write also updates the predicted config
  task automatic apb_access(input logic write, input logic [1:0] idx,
                            input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (write) begin
      case (idx)
        REG_FRAME_TIMEOUT: shadow_cfg.frame_timeout = value;
        REG_OVERRUN_LIMIT: shadow_cfg.overrun_limit = value;
        REG_LOAD_LIMIT:    shadow_cfg.load_limit = value[15:0];
        default:           shadow_cfg.error_mask = value[15:0];
      endcase
    end else if (prdata !== value) begin
      flag_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata, value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
    apb_access(1'b1, idx, value);
    apb_access(1'b0, idx, value);
  endtask

  task automatic send_word(input item_t w);
    while (tx_gaps_on && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Let every outstanding status word come back before touching the registers
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic item_t frame_word(input logic [31:0] now, input logic [31:0] seq,
                                       input logic [31:0] ovr, input logic [15:0] load,
                                       input logic [15:0] errs);
    item_t w;
    w.action = ACT_FRAME;
    w.now_time = now;
    w.frame_seq = seq;
    w.overrun_count = ovr;
    w.cpu_load = load;
    w.error_bits = errs;
    w.speed = 16'($urandom);  // ignored on frames
    gen_prev_seq = seq;
    return w;
  endfunction

  function automatic item_t tick_word(input logic [31:0] now, input logic signed [15:0] spd);
    item_t w;
    w.action = ACT_TICK;
    w.now_time = now;
    // frame fields are ignored on ticks
    w.frame_seq = $urandom;
    w.overrun_count = $urandom;
    w.cpu_load = 16'($urandom);
    w.error_bits = 16'($urandom);
    w.speed = spd;
    return w;
  endfunction

  // Next sequence number; with keep_clear set it never makes a third stall in a row
  function automatic logic [31:0] pick_seq(input bit keep_clear);
    logic [31:0] s;
    bit stalls;
    case ($urandom_range(3))
      0:       s = $urandom;
      1:       s = gen_prev_seq;
      default: s = gen_prev_seq + $urandom_range(1, 1000);
    endcase
    stalls = (s <= gen_prev_seq) && (gen_prev_seq != 0);
    if (stalls && keep_clear && gen_stall_run >= 2) begin
      s = gen_prev_seq + 1;
      stalls = (s <= gen_prev_seq) && (gen_prev_seq != 0);
    end
    gen_stall_run = stalls ? gen_stall_run + 1 : 0;
    return s;
  endfunction

  // Random frames and ticks; fast_only keeps tick speeds at or above the stop threshold
  task automatic send_random_mix(input int unsigned count, input bit keep_clear,
                                 input bit fast_only);
    logic [31:0] seq;
    logic signed [15:0] spd;
    repeat (count) begin
      if ($urandom_range(1) == 0) begin
        seq = pick_seq(keep_clear);
        send_word(frame_word($urandom, seq, $urandom, 16'($urandom), 16'($urandom)));
      end else begin
        spd = fast_only ? 16'($urandom_range(STOP_SPEED, 32767)) : 16'($urandom);
        send_word(tick_word($urandom, spd));
      end
    end
  endtask

  task automatic test_register_defaults();
    apb_access(1'b0, REG_FRAME_TIMEOUT, 32'd100);
    apb_access(1'b0, REG_OVERRUN_LIMIT, 32'd0);
    apb_access(1'b0, REG_LOAD_LIMIT, 32'd1000);
    apb_access(1'b0, REG_ERROR_MASK, 32'd3);
  endtask

  // Normal mode under reset config: limits at their edges, stall runs that clear,
  // timeout exactly at the limit, and elapsed time across the 32-bit wrap
  task automatic test_normal_edges();
    send_word(frame_word(32'd0, 32'd0, 32'd0, 16'd0, 16'd0));
    send_word(frame_word(32'd10, 32'd1, 32'd0, 16'd1000, 16'hFFFC));
    send_word(tick_word(32'd110, -16'sd32768));
    send_word(frame_word(32'd120, 32'd1, 32'd0, 16'd0, 16'h0000));
    send_word(frame_word(32'd121, 32'd0, 32'd0, 16'd999, 16'h0004));
    send_word(frame_word(32'd122, 32'd2, 32'd0, 16'd0, 16'h0000));
    send_word(frame_word(32'd123, 32'd2, 32'd0, 16'd0, 16'h0000));
    send_word(frame_word(32'd124, 32'd2, 32'd0, 16'd0, 16'h0000));
    send_word(frame_word(32'd125, 32'h8000_0000, 32'd0, 16'd0, 16'h0000));
    send_word(tick_word(32'd200, 16'sd32767));
    send_word(frame_word(32'hFFFF_FFC0, 32'h8000_0001, 32'd0, 16'd0, 16'h0000));
    send_word(tick_word(32'h0000_0024, 16'sd0));
    gen_stall_run = 0;
  endtask

  // Wide-open limits keep the monitor in normal mode while every field runs full range
  task automatic test_normal_traffic();
    drain_results();
    set_register(REG_FRAME_TIMEOUT, 32'hFFFF_FFFF);
    set_register(REG_OVERRUN_LIMIT, 32'hFFFF_FFFF);
    set_register(REG_LOAD_LIMIT, 32'h0000_FFFF);
    set_register(REG_ERROR_MASK, 32'h0000_0000);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    send_random_mix(150, 1'b1, 1'b0);
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    send_random_mix(550, 1'b1, 1'b0);
  endtask

  // Receiver holds off while the sender keeps offering words back to back
  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    ready_hold = 80;
    send_random_mix(40, 1'b1, 1'b0);
    tx_gaps_on = 1'b1;
  endtask

  // CPU load faults latch and move the monitor to degraded
  task automatic test_degraded();
    drain_results();
    set_register(REG_LOAD_LIMIT, 32'd1000);
    send_random_mix(300, 1'b1, 1'b0);
  endtask

  // Overrun and primary-error faults move degraded to controlled stop
  task automatic test_controlled_stop();
    drain_results();
    set_register(REG_OVERRUN_LIMIT, 32'h7FFF_FFFF);
    set_register(REG_ERROR_MASK, 32'h0000_8000);
    send_random_mix(300, 1'b1, 1'b1);
    // exactly at the stop threshold is not slow
    send_word(tick_word($urandom, STOP_SPEED));
  endtask

  // Leave controlled stop by one of its exits, chosen per run
  task automatic test_stop_exit();
    logic [31:0] t0;
    int unsigned exit_route;
    exit_route = $urandom_range(2);
    t0 = $urandom;
    drain_results();
    if (exit_route == 2) begin
      // slow without a timeout
      send_word(tick_word($urandom, -16'sd32768));
    end else begin
      set_register(REG_FRAME_TIMEOUT, 32'd0);
      send_word(frame_word(t0, pick_seq(1'b1), 32'd0, 16'd0, 16'd0));
      if (exit_route == 0) begin
        // timeout and slow on the same tick: safe stop wins
        send_word(tick_word(t0 + 1, STOP_SPEED - 16'sd1));
      end else begin
        send_word(tick_word(t0 + 5, STOP_SPEED));
        send_random_mix(200, 1'b1, 1'b1);
        send_word(tick_word($urandom, -16'sd1));
      end
    end
  endtask

  // Safe stop latches: arbitrary traffic and config never release it
  task automatic test_safe_latched();
    drain_results();
    set_register(REG_FRAME_TIMEOUT, $urandom_range(0, 1000));
    set_register(REG_OVERRUN_LIMIT, $urandom);
    set_register(REG_LOAD_LIMIT, 32'd0);
    set_register(REG_ERROR_MASK, 32'h0000_FFFF);
    send_random_mix(450, 1'b0, 1'b0);
  endtask

  initial begin
    shadow_cfg.frame_timeout = 32'd100;
    shadow_cfg.overrun_limit = 32'd0;
    shadow_cfg.load_limit = 16'd1000;
    shadow_cfg.error_mask = 16'd3;
    m_mode = MODE_NORMAL;
    m_prev_seq = '0;
    m_last_time = '0;
    m_stall = '0;
    m_faults = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_defaults();
    test_normal_edges();
    test_normal_traffic();
    test_output_backpressure();
    test_degraded();
    test_controlled_stop();
    test_stop_exit();
    test_safe_latched();

    drain_results();
    if (expected_status.size() != 0)
      flag_mismatch($sformatf("%0d status words never arrived", expected_status.size()));
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
